// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion shorthands, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/rwtt_pkg.sv -----
// ----------------------------------------------------------------------------
// rwtt_pkg
// Types and codes shared by the range window translation table.
// ----------------------------------------------------------------------------
`default_nettype none

package rwtt_pkg;

    localparam int DEFAULT_TABLE_ENTRIES = 16;

    // Request kinds
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_OVERLAP    = 3'd1;
    localparam logic [2:0] ST_FULL       = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
    localparam logic [2:0] ST_BAD_LENGTH = 3'd4;

    // One stored window
    typedef struct packed {
        logic [31:0] src;
        logic [31:0] len;
        logic [31:0] tgt;
    } entry_t;

    // Outcome of one entry compare
    typedef struct packed {
        logic        overlap;
        logic        start_eq;
        logic [32:0] end_addr;
    } cmp_res_t;

endpackage

`default_nettype wire

// ----- design/rwtt_store.sv -----
// ----------------------------------------------------------------------------
// rwtt_store
// Window table: entry memory with one write and one registered read port,
// plus per-entry valid flags cleared by reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rwtt_store
    import rwtt_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES,
    parameter int IDX_W         = 4
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic             clr_en,
    input  wire logic [IDX_W-1:0] wr_idx,
    input  wire entry_t           wr_entry,
    input  wire logic [IDX_W-1:0] rd_idx,
    output entry_t                rd_entry,
    output logic                  rd_valid
);

    entry_t                   mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;
    entry_t                   rd_entry_reg;
    logic                     rd_valid_reg;

    // Write and read the entry memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_entry;
        end
        rd_entry_reg <= mem[rd_idx];
    end

    // Track valid flags; set on write, drop on delete
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            else if (clr_en)
            begin
                valid_reg[wr_idx] <= 1'b0;
            end
            rd_valid_reg <= valid_reg[rd_idx];
        end
    end

    assign rd_entry = rd_entry_reg;
    assign rd_valid = rd_valid_reg;

endmodule

`default_nettype wire

// ----- design/rwtt_cmp_unit.sv -----
// ----------------------------------------------------------------------------
// rwtt_cmp_unit
// Shared compare unit: tests one stored window against the request range
// [req_start, req_end) and for an exact start match.
// ----------------------------------------------------------------------------
`default_nettype none

module rwtt_cmp_unit
    import rwtt_pkg::*;
(
    input  wire entry_t      entry,
    input  wire logic [31:0] req_start,
    input  wire logic [32:0] req_end,
    output cmp_res_t         res
);

    logic [32:0] entry_end;

    // Exclusive end of the stored window, 33 bits
    assign entry_end = {1'b0, entry.src} + {1'b0, entry.len};

    // Plain interval overlap of two half-open ranges
    always_comb
    begin
        res.end_addr = entry_end;
        res.overlap  = ({1'b0, req_start} < entry_end) && ({1'b0, entry.src} < req_end);
        res.start_eq = (entry.src == req_start);
    end

endmodule

`default_nettype wire

// ----- design/range_window_translation_table.sv -----
// Sequence: S_IDLE takes a request, S_SETUP checks it, S_SCAN walks every entry,
//   S_CALC resolves it and S_FINISH loads the result once the output register is free;
//   a bad length insert or an unused request kind goes from S_SETUP straight to S_FINISH.
// Flow: one request at a time, walked through the single read port and shared compare unit.
// Reset: rst_n clears all valid flags and the sequencer at once; entry data is not cleared.
// ----------------------------------------------------------------------------
// range_window_translation_table
// Table of address windows with insert, delete and lookup, served by a
// sequencer that walks the table through one shared compare unit.
// ----------------------------------------------------------------------------
`default_nettype none

module range_window_translation_table
    import rwtt_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [31:0] address, [63:32] target_base, [95:64] window_length, [127:96] request_length
    input  wire logic [127:0] s_axis_tdata,
    // [1:0] req_type
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [31:0] target_address, [63:32] copy_bytes
    output logic [63:0]       m_axis_tdata,
    // [2:0] status
    output logic [2:0]        m_axis_tuser
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_SCAN,
        S_CALC,
        S_FINISH
    } state_t;

    state_t      state_reg;
    logic [1:0]  req_type_reg;
    logic [31:0] addr_reg;
    logic [31:0] tbase_reg;
    logic [31:0] wlen_reg;
    logic [31:0] rlen_reg;
    logic [32:0] req_end_reg;

    logic [CNT_W-1:0] rd_cnt_reg;
    logic             cmp_live_reg;
    logic [IDX_W-1:0] cmp_idx_reg;

    logic             hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic [31:0]      hit_src_reg;
    logic [32:0]      hit_end_reg;
    logic [31:0]      hit_tgt_reg;
    logic [31:0]      offs_reg;
    logic [32:0]      left_reg;
    logic [2:0]       res_status_reg;

    logic             out_valid_reg;
    logic [2:0]       out_status_reg;
    logic [31:0]      out_tgt_reg;
    logic [31:0]      out_copy_reg;

    logic             tbl_wr_en;
    logic             tbl_clr_en;
    logic [IDX_W-1:0] tbl_wr_idx;
    entry_t           tbl_wr_entry;
    logic [IDX_W-1:0] tbl_rd_idx;
    entry_t           tbl_rd_entry;
    logic             tbl_rd_valid;
    cmp_res_t         cmp_res;

    logic [32:0]      setup_end;
    logic             setup_bad;
    logic             scan_more;
    logic             out_free;
    logic             lookup_hit;

    // Table storage
    rwtt_store #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (tbl_wr_en),
        .clr_en   (tbl_clr_en),
        .wr_idx   (tbl_wr_idx),
        .wr_entry (tbl_wr_entry),
        .rd_idx   (tbl_rd_idx),
        .rd_entry (tbl_rd_entry),
        .rd_valid (tbl_rd_valid)
    );

    // Shared compare unit
    rwtt_cmp_unit u_cmp (
        .entry     (tbl_rd_entry),
        .req_start (addr_reg),
        .req_end   (req_end_reg),
        .res       (cmp_res)
    );

    // Request range end and length check
    always_comb
    begin
        if (req_type_reg == REQ_LOOKUP)
        begin
            setup_end = {1'b0, addr_reg} + 33'd1;
        end
        else
        begin
            setup_end = {1'b0, addr_reg} + {1'b0, wlen_reg};
        end
        setup_bad = (req_type_reg == REQ_INSERT) &&
                    ((wlen_reg == 32'd0) || (setup_end[32] && (setup_end[31:0] != 32'd0)));
    end

    // Table port control
    always_comb
    begin
        scan_more    = (rd_cnt_reg < CNT_W'(TABLE_ENTRIES));
        tbl_rd_idx   = rd_cnt_reg[IDX_W-1:0];
        tbl_wr_en    = (state_reg == S_CALC) && (req_type_reg == REQ_INSERT) &&
                       !hit_reg && free_found_reg;
        tbl_clr_en   = (state_reg == S_CALC) && (req_type_reg == REQ_DELETE) && hit_reg;
        tbl_wr_idx   = (req_type_reg == REQ_INSERT) ? free_idx_reg : hit_idx_reg;
        tbl_wr_entry = '{src: addr_reg, len: wlen_reg, tgt: tbase_reg};
        out_free     = !out_valid_reg || m_axis_tready;
        lookup_hit   = (req_type_reg == REQ_LOOKUP) && hit_reg;
    end

    // Sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rd_cnt_reg     <= '0;
            cmp_live_reg   <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // Drop the result once it is taken, unless a new one loads now
            if (out_valid_reg && m_axis_tready && !((state_reg == S_FINISH) && out_free))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        req_type_reg <= s_axis_tuser;
                        addr_reg     <= s_axis_tdata[31:0];
                        tbase_reg    <= s_axis_tdata[63:32];
                        wlen_reg     <= s_axis_tdata[95:64];
                        rlen_reg     <= s_axis_tdata[127:96];
                        state_reg    <= S_SETUP;
                    end
                end

                S_SETUP:
                begin
                    req_end_reg    <= setup_end;
                    rd_cnt_reg     <= '0;
                    cmp_live_reg   <= 1'b0;
                    hit_reg        <= 1'b0;
                    free_found_reg <= 1'b0;
                    if (setup_bad)
                    begin
                        res_status_reg <= ST_BAD_LENGTH;
                        state_reg      <= S_FINISH;
                    end
                    else if ((req_type_reg != REQ_INSERT) && (req_type_reg != REQ_DELETE) &&
                             (req_type_reg != REQ_LOOKUP))
                    begin
                        res_status_reg <= ST_NOT_FOUND;
                        state_reg      <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_SCAN;
                    end
                end

                S_SCAN:
                begin
                    // Advance the read pointer
                    if (scan_more)
                    begin
                        rd_cnt_reg   <= rd_cnt_reg + CNT_W'(1);
                        cmp_idx_reg  <= rd_cnt_reg[IDX_W-1:0];
                        cmp_live_reg <= 1'b1;
                    end
                    else
                    begin
                        cmp_live_reg <= 1'b0;
                    end

                    // Judge the entry read in the previous cycle
                    if (cmp_live_reg)
                    begin
                        if (tbl_rd_valid)
                        begin
                            if (!hit_reg &&
                                (((req_type_reg == REQ_DELETE) && cmp_res.start_eq) ||
                                 ((req_type_reg != REQ_DELETE) && cmp_res.overlap)))
                            begin
                                hit_reg     <= 1'b1;
                                hit_idx_reg <= cmp_idx_reg;
                                hit_src_reg <= tbl_rd_entry.src;
                                hit_end_reg <= cmp_res.end_addr;
                                hit_tgt_reg <= tbl_rd_entry.tgt;
                            end
                        end
                        else if (!free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= cmp_idx_reg;
                        end

                        if (cmp_idx_reg == IDX_W'(TABLE_ENTRIES - 1))
                        begin
                            state_reg <= S_CALC;
                        end
                    end
                end

                S_CALC:
                begin
                    offs_reg  <= hit_tgt_reg - hit_src_reg;
                    left_reg  <= hit_end_reg - {1'b0, addr_reg};
                    state_reg <= S_FINISH;
                    priority if (req_type_reg == REQ_INSERT)
                    begin
                        if (hit_reg)
                        begin
                            res_status_reg <= ST_OVERLAP;
                        end
                        else if (!free_found_reg)
                        begin
                            res_status_reg <= ST_FULL;
                        end
                        else
                        begin
                            res_status_reg <= ST_OK;
                        end
                    end
                    else
                    begin
                        res_status_reg <= hit_reg ? ST_OK : ST_NOT_FOUND;
                    end
                end

                S_FINISH:
                begin
                    // Load the result once the output register is free
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        if (lookup_hit)
                        begin
                            out_tgt_reg  <= addr_reg + offs_reg;
                            out_copy_reg <= ({1'b0, rlen_reg} < left_reg) ?
                                            rlen_reg : left_reg[31:0];
                        end
                        else
                        begin
                            out_tgt_reg  <= 32'd0;
                            out_copy_reg <= 32'd0;
                        end
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_copy_reg, out_tgt_reg};
    assign m_axis_tuser  = out_status_reg;

endmodule

`default_nettype wire

// ----- design/rwtt_checker.sv -----
// ----------------------------------------------------------------------------
// rwtt_checker
// Port-level checks for the range window translation table, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rwtt_checker
    import rwtt_pkg::*;
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [63:0]  m_axis_tdata,
    input wire logic [2:0]   m_axis_tuser
);

    logic        in_xfer;
    logic        out_stall;
    logic        out_fail;
    logic [66:0] out_word;

    // Handshake and result shorthands
    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_fail  = m_axis_tvalid && (m_axis_tuser != ST_OK);
    assign out_word  = {m_axis_tuser, m_axis_tdata};

    // Not ready in the cycle after taking a request
    `ASSERT_NEXT(a_busy_after_take, in_xfer, !s_axis_tready, "ready after transfer")

    // Hold a stalled result
    `ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_word), "stalled result changed")

    // Status stays within the defined codes
    `ASSERT_IMPL(a_status_range, m_axis_tvalid, m_axis_tuser <= ST_BAD_LENGTH, "bad status code")

    // Data is zero unless the request succeeded
    `ASSERT_IMPL(a_zero_on_fail, out_fail, m_axis_tdata == 64'd0, "nonzero data on failed request")

endmodule

bind range_window_translation_table rwtt_checker u_rwtt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ----- tb/sv/range_window_translation_table_tb.sv -----
// ----------------------------------------------------------------------------
// range_window_translation_table_tb
// Self-checking bench for the window translation table. A short table of
// directed requests covers empty-table misses, bad lengths, windows at both
// ends of the address space, overlaps and deletes. Random bursts follow: fill
// bursts that pack a fresh region until the table is full, local churn that
// mixes inserts, deletes of stored windows and lookups inside them, and raw
// noise. A bench-side copy of the table predicts every result, and each
// output transfer is checked field by field in order.
// ----------------------------------------------------------------------------

module range_window_translation_table_tb;

    import rwtt_pkg::*;

    localparam int          ENTRIES      = DEFAULT_TABLE_ENTRIES;
    localparam int          RANDOM_ITEMS = 880;
    localparam int          STALL_LIMIT  = 2000;
    localparam int          DRAIN_CYCLES = 30;
    localparam logic [1:0]  REQ_UNUSED   = 2'd3;
    localparam bit          TYPED        = 1'b1;
    localparam bit          PREDICT      = 1'b0;

    // Random burst flavors
    localparam int PROF_FILL  = 0;
    localparam int PROF_CHURN = 1;
    localparam int PROF_NOISE = 2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [31:0] tbase;
        logic [31:0] wlen;
        logic [31:0] rlen;
    } xlat_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] tgt;
        logic [31:0] copy;
    } xlat_rsp_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [31:0] tbase;
        logic [31:0] wlen;
        logic [31:0] rlen;
        bit          typed;
        logic [2:0]  status;
        logic [31:0] tgt;
        logic [31:0] copy;
    } dir_row_t;

    logic           clk           = 1'b0;
    logic           rst_n         = 1'b0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [127:0]   s_axis_tdata  = '0;
    logic [1:0]     s_axis_tuser  = REQ_INSERT;
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [63:0]    m_axis_tdata;
    logic [2:0]     m_axis_tuser;

    // Bench copy of the window table
    bit             win_valid [ENTRIES];
    logic [31:0]    win_src   [ENTRIES];
    logic [31:0]    win_len   [ENTRIES];
    logic [31:0]    win_tgt   [ENTRIES];

    xlat_rsp_t      expected_results [$];
    int             fail_count  = 0;
    int             stall_count = 0;
    bit             steady      = 1'b0;
    logic [31:0]    region_base = '0;

    // Directed requests; typed rows carry their own answer
    dir_row_t directed_rows [24] = '{
        // empty table
        '{REQ_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h0, TYPED, ST_NOT_FOUND, 32'h0, 32'h0},
        '{REQ_DELETE, 32'h0, 32'h0, 32'h0, 32'h0, TYPED, ST_NOT_FOUND, 32'h0, 32'h0},
        '{REQ_UNUSED, '1, '1, '1, '1, TYPED, ST_NOT_FOUND, 32'h0, 32'h0},
        // zero length and windows running past the top of the space
        '{REQ_INSERT, 32'h1000, 32'h0, 32'h0, 32'h0, TYPED, ST_BAD_LENGTH, 32'h0, 32'h0},
        '{REQ_INSERT, '1, 32'h0, 32'h2, 32'h0, TYPED, ST_BAD_LENGTH, 32'h0, 32'h0},
        '{REQ_INSERT, 32'h2, 32'h0, '1, 32'h0, TYPED, ST_BAD_LENGTH, 32'h0, 32'h0},
        // last byte of the space, then the largest window below it
        '{REQ_INSERT, '1, 32'h1234_5678, 32'h1, '1, TYPED, ST_OK, 32'h0, 32'h0},
        '{REQ_INSERT, 32'h0, '1, '1, '1, TYPED, ST_OK, 32'h0, 32'h0},
        '{REQ_LOOKUP, '1, '1, '1, '1, TYPED, ST_OK, 32'h1234_5678, 32'h1},
        '{REQ_LOOKUP, 32'h0, '1, '1, 32'h0, TYPED, ST_OK, '1, 32'h0},
        '{REQ_LOOKUP, 32'h8000_0000, 32'h0, 32'h0, '1, PREDICT, ST_OK, 32'h0, 32'h0},
        '{REQ_LOOKUP, 32'hFFFF_FFFE, 32'h0, 32'h0, 32'h5, PREDICT, ST_OK, 32'h0, 32'h0},
        // overlap inside a window and on a duplicate start
        '{REQ_INSERT, 32'h10, 32'h0, 32'h1, 32'h0, TYPED, ST_OVERLAP, 32'h0, 32'h0},
        '{REQ_INSERT, '1, 32'h0, 32'h1, 32'h0, TYPED, ST_OVERLAP, 32'h0, 32'h0},
        // delete needs an exact start
        '{REQ_DELETE, 32'h5, 32'h0, 32'h0, 32'h0, TYPED, ST_NOT_FOUND, 32'h0, 32'h0},
        '{REQ_DELETE, 32'h0, 32'h0, 32'h0, 32'h0, TYPED, ST_OK, 32'h0, 32'h0},
        '{REQ_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h10, TYPED, ST_NOT_FOUND, 32'h0, 32'h0},
        // adjacent, tail-overlapping and covering windows
        '{REQ_INSERT, 32'h100, 32'hA000_0000, 32'h100, 32'h0, PREDICT, ST_OK, 32'h0, 32'h0},
        '{REQ_INSERT, 32'hF0, 32'h5555_0000, 32'h10, 32'h0, PREDICT, ST_OK, 32'h0, 32'h0},
        '{REQ_INSERT, 32'h1FF, 32'h0, 32'h2, 32'h0, PREDICT, ST_OK, 32'h0, 32'h0},
        '{REQ_INSERT, 32'h0, 32'h0, 32'h1000, 32'h0, PREDICT, ST_OK, 32'h0, 32'h0},
        '{REQ_LOOKUP, 32'h1F0, 32'h0, 32'h0, 32'h100, PREDICT, ST_OK, 32'h0, 32'h0},
        '{REQ_DELETE, '1, 32'h0, 32'h0, 32'h0, TYPED, ST_OK, 32'h0, 32'h0},
        '{REQ_DELETE, '1, 32'h0, 32'h0, 32'h0, TYPED, ST_NOT_FOUND, 32'h0, 32'h0}
    };

    range_window_translation_table #(
        .TABLE_ENTRIES (ENTRIES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Idle at a chance of 16 in a hundred, never inside the steady stretch
    function automatic bit take_gap();
        return !steady && ($urandom_range(99) < 16);
    endfunction

    // Apply one request to the bench table and return its answer
    function automatic xlat_rsp_t translate_request(input xlat_req_t r);
        xlat_rsp_t   rsp;
        logic [32:0] new_end;
        logic [32:0] old_end;
        int          free_slot;
        bit          done;

        rsp.status = ST_NOT_FOUND;
        rsp.tgt    = '0;
        rsp.copy   = '0;
        done       = 1'b0;
        free_slot  = -1;
        new_end    = {1'b0, r.addr} + {1'b0, r.wlen};

        case (r.kind)
            REQ_INSERT:
            begin
                if (r.wlen == '0 || new_end > 33'h1_0000_0000)
                begin
                    rsp.status = ST_BAD_LENGTH;
                end
                else
                begin
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (win_valid[i])
                        begin
                            old_end = {1'b0, win_src[i]} + {1'b0, win_len[i]};
                            if ({1'b0, r.addr} < old_end && {1'b0, win_src[i]} < new_end)
                                done = 1'b1;
                        end
                        else if (free_slot < 0)
                        begin
                            free_slot = i;
                        end
                    end
                    if (done)
                        rsp.status = ST_OVERLAP;
                    else if (free_slot < 0)
                        rsp.status = ST_FULL;
                    else
                    begin
                        win_valid[free_slot] = 1'b1;
                        win_src[free_slot]   = r.addr;
                        win_len[free_slot]   = r.wlen;
                        win_tgt[free_slot]   = r.tbase;
                        rsp.status           = ST_OK;
                    end
                end
            end
            REQ_DELETE:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (!done && win_valid[i] && win_src[i] == r.addr)
                    begin
                        win_valid[i] = 1'b0;
                        rsp.status   = ST_OK;
                        done         = 1'b1;
                    end
                end
            end
            REQ_LOOKUP:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    old_end = {1'b0, win_src[i]} + {1'b0, win_len[i]};
                    if (!done && win_valid[i] && r.addr >= win_src[i]
                        && {1'b0, r.addr} < old_end)
                    begin
                        old_end    = old_end - {1'b0, r.addr};
                        rsp.status = ST_OK;
                        rsp.tgt    = r.addr + (win_tgt[i] - win_src[i]);
                        rsp.copy   = ({1'b0, r.rlen} < old_end) ? r.rlen : old_end[31:0];
                        done       = 1'b1;
                    end
                end
            end
            default:
            begin
                rsp.status = ST_NOT_FOUND;
            end
        endcase
        return rsp;
    endfunction

    // Build one random request; in churn, most deletes and lookups aim at stored windows
    function automatic xlat_req_t make_random_request(input int profile, input int step);
        xlat_req_t   r;
        int unsigned live [$];
        int unsigned slot;
        int unsigned pick;

        for (int i = 0; i < ENTRIES; i++)
            if (win_valid[i])
                live.push_back(i);

        r.kind  = REQ_INSERT;
        r.addr  = region_base + $urandom_range(0, 32'hFFF);
        r.tbase = $urandom;
        r.wlen  = $urandom_range(1, 32'h200);
        r.rlen  = $urandom;
        pick    = $urandom_range(99);

        if (profile == PROF_NOISE)
        begin
            r.kind = 2'($urandom_range(0, 3));
            r.addr = $urandom;
            r.wlen = $urandom;
        end
        else if (profile == PROF_FILL)
        begin
            // Pack disjoint windows through a fresh region
            r.addr = region_base + step * 32'h100;
            r.wlen = $urandom_range(1, 32'h100);
        end
        else if (pick < 45)
        begin
            if (pick < 3)
                r.wlen = '0;
            else if (pick < 6)
                r.wlen = $urandom;
        end
        else if (pick < 65)
        begin
            r.kind = REQ_DELETE;
            if (live.size() != 0 && pick < 60)
                r.addr = win_src[live[$urandom_range(0, live.size() - 1)]];
        end
        else
        begin
            r.kind = REQ_LOOKUP;
            if (live.size() != 0 && pick < 93)
            begin
                slot = live[$urandom_range(0, live.size() - 1)];
                case ($urandom_range(0, 3))
                    0:       r.addr = win_src[slot];
                    1:       r.addr = win_src[slot] + win_len[slot] - 1;
                    default: r.addr = win_src[slot] + ($urandom % win_len[slot]);
                endcase
            end
            case ($urandom_range(0, 3))
                0:       r.rlen = $urandom_range(0, 16);
                1:       r.rlen = $urandom_range(0, 32'h400);
                2:       r.rlen = '1;
                default: r.rlen = $urandom;
            endcase
        end
        return r;
    endfunction

    // Present one request and hold it until the transfer
    task automatic send_request(input xlat_req_t r);
        @(negedge clk);
        while (take_gap())
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r.rlen, r.wlen, r.tbase, r.addr};
        s_axis_tuser  <= r.kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
            fail_count++;
        end
    endfunction

    // Stall the result side at random
    always @(negedge clk)
    begin
        m_axis_tready <= !take_gap();
    end

    // Check each result transfer against the oldest expectation
    always @(posedge clk)
    begin : result_check
        xlat_rsp_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual status %0d",
                         $time, m_axis_tuser);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("status", {29'b0, want.status}, {29'b0, m_axis_tuser});
                check_field("target_address", want.tgt, m_axis_tdata[31:0]);
                check_field("copy_bytes", want.copy, m_axis_tdata[63:32]);
            end
        end
    end

    // Count cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_count <= 0;
            else
                stall_count <= stall_count + 1;
            if (stall_count >= STALL_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Reset, directed table, random bursts, drain
    initial
    begin
        xlat_req_t req;
        xlat_rsp_t rsp;
        int        sent;
        int        burst_len;
        int        profile;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            req.kind  = directed_rows[i].kind;
            req.addr  = directed_rows[i].addr;
            req.tbase = directed_rows[i].tbase;
            req.wlen  = directed_rows[i].wlen;
            req.rlen  = directed_rows[i].rlen;
            send_request(req);
            rsp = translate_request(req);
            if (directed_rows[i].typed)
            begin
                rsp.status = directed_rows[i].status;
                rsp.tgt    = directed_rows[i].tgt;
                rsp.copy   = directed_rows[i].copy;
            end
            expected_results.push_back(rsp);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            // Pick the burst flavor and its region; some regions hug the top
            case ($urandom_range(0, 9))
                0, 1:    profile = PROF_FILL;
                2, 3:    profile = PROF_NOISE;
                default: profile = PROF_CHURN;
            endcase
            region_base = ($urandom_range(0, 7) == 0) ? 32'hFFFF_F000 : ($urandom & 32'hFFFF_F000);
            burst_len   = (profile == PROF_FILL) ? $urandom_range(18, 22) : $urandom_range(10, 40);
            for (int k = 0; k < burst_len && sent < RANDOM_ITEMS; k++)
            begin
                steady = (sent >= 400 && sent < 550);
                req    = make_random_request(profile, k);
                send_request(req);
                expected_results.push_back(translate_request(req));
                sent++;
            end
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        steady = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
